// ----- src/lpdcb_pkg.sv -----
// ----------------------------------------------------------------------------
// lpdcb_pkg
// Shared widths and constants for the linear-phase DC blocker.
// ----------------------------------------------------------------------------
package lpdcb_pkg;

	localparam int SAMPLE_W = 24;
	localparam int NSTAGES  = 4;

	// Output queue that decouples the pipeline from the downstream stall.
	localparam int FIFO_AW    = 4;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	localparam logic [SAMPLE_W-1:0] SAT_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] SAT_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

endpackage

// ----- src/linear_phase_dc_blocker.sv -----
// ----------------------------------------------------------------------------
// linear_phase_dc_blocker
// Cascade of four moving averages subtracted from a delayed copy of the input.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_ stream (s_tdata = signed 24-bit sample) and leave
//   on the m_ stream, one result per transaction, in order. Each result is the
//   input delayed by ORDER samples minus the fourth moving-average stage, with
//   saturation to 24 bits. ORDER must be a power of two.
//   All delay lines live in single-port memories of ORDER words, one for the
//   long delay and one per averaging stage, each read and written at the
//   shared ring position. Every stage does a memory access, then a
//   running sum update.
//   Path: a result passes 8 pipeline registers, then the output queue,
//   before m_tvalid rises. Throughput is one sample per cycle while
//   s_tready is high, with a single memory port per delay line.
//   A 16-entry output queue with credit counting keeps s_tready high while
//   fewer than 16 transactions are outstanding, so a stalled receiver only
//   throttles the input once 16 transactions are outstanding.
//   Reset clears the ring position, running sums and control state. Memory
//   contents are not cleared; a lap flag makes every entry read as zero until
//   the ring has wrapped once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module linear_phase_dc_blocker
	import lpdcb_pkg::*;
#(
	parameter int ORDER = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [SAMPLE_W-1:0] s_tdata,   // [23:0] sample_in
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [SAMPLE_W-1:0] m_tdata    // [23:0] sample_out
);

	localparam int PW    = $clog2(ORDER);
	localparam int SUM_W = SAMPLE_W + PW;

	typedef struct packed {
		logic                vld;
		logic                wrap;
		logic [PW-1:0]       ptr;
		logic [SAMPLE_W-1:0] dly;
	} tag_t;

	logic [PW-1:0]       ptr_q;
	logic                wrapped_q;
	logic                in_acc;
	logic                out_acc;

	logic [SAMPLE_W-1:0] long_mem [ORDER];
	logic [SAMPLE_W-1:0] long_rd_s1;

	tag_t                stg_tag [NSTAGES+1];
	logic [SAMPLE_W-1:0] stg_x   [NSTAGES+1];

	logic [SAMPLE_W:0]   diff;
	logic [SAMPLE_W-1:0] result;

	logic [SAMPLE_W-1:0] fifo_mem [FIFO_DEPTH];
	logic [FIFO_AW:0]    wr_ptr_q;
	logic [FIFO_AW:0]    rd_ptr_q;
	logic [FIFO_AW:0]    cred_q;

	assign in_acc  = s_tvalid & s_tready;
	assign out_acc = m_tvalid & m_tready;

	// Ring position, shared by all delay lines. The lap flag tells whether the
	// entry at the current position has ever been written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			wrapped_q <= 1'b0;
		end else if (in_acc) begin
			if (ptr_q == PW'(ORDER - 1)) begin
				ptr_q     <= '0;
				wrapped_q <= 1'b1;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			long_rd_s1       <= long_mem[ptr_q];
			long_mem[ptr_q]  <= s_tdata;
		end
	end

	assign stg_tag[0] = '{vld: in_acc, wrap: wrapped_q, ptr: ptr_q, dly: '0};
	assign stg_x[0]   = s_tdata;

	for (genvar j = 0; j < NSTAGES; j++) begin : g_stage
		logic [SAMPLE_W-1:0] dline_mem [ORDER];
		tag_t                tag_s1;
		tag_t                tag_s2;
		logic [SAMPLE_W-1:0] x_s1;
		logic [SAMPLE_W-1:0] rd_s1;
		logic [SAMPLE_W-1:0] old;
		logic [SAMPLE_W-1:0] dly_nxt;
		logic [SUM_W-1:0]    sum_q;

		// Read-first single port: the old word leaves as the new one goes in.
		always_ff @(posedge clk) begin
			if (stg_tag[j].vld) begin
				rd_s1                      <= dline_mem[stg_tag[j].ptr];
				dline_mem[stg_tag[j].ptr]  <= stg_x[j];
			end
			x_s1 <= stg_x[j];
		end

		assign old = tag_s1.wrap ? rd_s1 : '0;

		// The first stage picks up the long delay word, which also reads as zero
		// until the ring has wrapped once.
		if (j == 0) begin : g_dly_load
			assign dly_nxt = tag_s1.wrap ? long_rd_s1 : '0;
		end else begin : g_dly_pass
			assign dly_nxt = tag_s1.dly;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s1 <= '0;
				tag_s2 <= '0;
				sum_q  <= '0;
			end else begin
				tag_s1 <= stg_tag[j];
				tag_s2 <= '{vld: tag_s1.vld, wrap: tag_s1.wrap, ptr: tag_s1.ptr,
					dly: dly_nxt};
				if (tag_s1.vld) begin
					sum_q <= sum_q + {{PW{x_s1[SAMPLE_W-1]}}, x_s1}
						- {{PW{old[SAMPLE_W-1]}}, old};
				end
			end
		end

		// The sum of ORDER 24-bit words shifted right by log2(ORDER) fits 24 bits.
		assign stg_tag[j+1] = tag_s2;
		assign stg_x[j+1]   = sum_q[SUM_W-1 -: SAMPLE_W];
	end

	assign diff = {stg_tag[NSTAGES].dly[SAMPLE_W-1], stg_tag[NSTAGES].dly}
		- {stg_x[NSTAGES][SAMPLE_W-1], stg_x[NSTAGES]};

	always_comb begin
		if (diff[SAMPLE_W] != diff[SAMPLE_W-1]) begin
			result = diff[SAMPLE_W] ? SAT_NEG : SAT_POS;
		end else begin
			result = diff[SAMPLE_W-1:0];
		end
	end

	// Output queue. Credits count every transaction accepted and not yet
	// delivered, so a queue slot is always free when a result arrives.
	always_ff @(posedge clk) begin
		if (stg_tag[NSTAGES].vld) begin
			fifo_mem[wr_ptr_q[FIFO_AW-1:0]] <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cred_q   <= '0;
		end else begin
			if (stg_tag[NSTAGES].vld) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (in_acc && !out_acc) begin
				cred_q <= cred_q + 1'b1;
			end else if (!in_acc && out_acc) begin
				cred_q <= cred_q - 1'b1;
			end
		end
	end

	assign s_tready = (cred_q != (FIFO_AW+1)'(FIFO_DEPTH));
	assign m_tvalid = (wr_ptr_q != rd_ptr_q);
	assign m_tdata  = fifo_mem[rd_ptr_q[FIFO_AW-1:0]];

endmodule

// ----- src/lpdcb_chk.sv -----
// ----------------------------------------------------------------------------
// lpdcb_chk
// Port-level checks for the linear-phase DC blocker, bound to the top level.
// ----------------------------------------------------------------------------
module lpdcb_chk
	import lpdcb_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [SAMPLE_W-1:0] s_tdata,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [SAMPLE_W-1:0] m_tdata
);

	logic [FIFO_AW+1:0] outstanding_q;
	logic               in_acc;
	logic               out_acc;

	assign in_acc  = s_tvalid & s_tready;
	assign out_acc = m_tvalid & m_tready;

	// Transactions accepted on the input and not yet delivered on the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (in_acc && !out_acc) begin
			outstanding_q <= outstanding_q + 1'b1;
		end else if (!in_acc && out_acc) begin
			outstanding_q <= outstanding_q - 1'b1;
		end
	end

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("m_tdata changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> outstanding_q != '0)
		else $error("result offered with no transaction outstanding");

	a_ready_credit: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q < (FIFO_AW+2)'(FIFO_DEPTH) |-> s_tready)
		else $error("input stalled although the output queue has room");

endmodule

bind linear_phase_dc_blocker lpdcb_chk u_lpdcb_chk (.*);

// ----- tb/sv/tb_linear_phase_dc_blocker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_phase_dc_blocker
// Self-checking bench for the linear-phase DC blocker. Every accepted sample
// runs through a bench-side model of the delay line and the four averaging
// stages. Each output transaction is checked against the oldest expected
// sample. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_linear_phase_dc_blocker;
	import lpdcb_pkg::*;

	localparam int ORDER         = 128;
	localparam int AVG_SHIFT     = $clog2(ORDER);
	localparam int TOTAL_SAMPLES = 1650;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_CYCLES  = 30;
	localparam longint SMAX      = longint'($signed(SAT_POS));
	localparam longint SMIN      = longint'($signed(SAT_NEG));

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [SAMPLE_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [SAMPLE_W-1:0] m_tdata;

	// Bench copy of the filter state.
	logic signed [SAMPLE_W-1:0] long_line [ORDER];
	logic signed [SAMPLE_W-1:0] stage_line [NSTAGES][ORDER];
	longint                     stage_sum [NSTAGES];
	int unsigned                ring_pos;

	logic [SAMPLE_W-1:0] expected_samples [$];
	int unsigned         samples_sent;
	int unsigned         mismatches;
	int unsigned         cycle_count;
	bit                  tx_gaps;
	bit                  rx_stalls;
	int unsigned         stall_left;

	linear_phase_dc_blocker #(
		.ORDER(ORDER)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint clamp24(longint v);
		if (v > SMAX) begin
			return SMAX;
		end
		if (v < SMIN) begin
			return SMIN;
		end
		return v;
	endfunction

	// Advances the bench state by one sample and returns the filtered sample.
	function automatic logic [SAMPLE_W-1:0] dcb_predict(logic [SAMPLE_W-1:0] sample);
		longint                     x;
		longint                     delayed;
		longint                     y;
		logic signed [SAMPLE_W-1:0] old;
		x = longint'($signed(sample));
		delayed = longint'(long_line[ring_pos]);
		long_line[ring_pos] = x[SAMPLE_W-1:0];
		for (int j = 0; j < NSTAGES; j++) begin
			old = stage_line[j][ring_pos];
			stage_line[j][ring_pos] = x[SAMPLE_W-1:0];
			stage_sum[j] = stage_sum[j] + x - longint'(old);
			// Arithmetic shift of a signed value rounds toward minus infinity.
			x = clamp24(stage_sum[j] >>> AVG_SHIFT);
		end
		y = clamp24(delayed - x);
		ring_pos = (ring_pos + 1) % ORDER;
		return y[SAMPLE_W-1:0];
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned draw_gap(bit enabled);
		int unsigned r;
		if (!enabled) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
		int unsigned gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= sample;
		do @(posedge clk); while (!s_tready);
		expected_samples.push_back(dcb_predict(sample));
		samples_sent++;
		gap = draw_gap(tx_gaps);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata  <= SAMPLE_W'($urandom);
		end
	endtask

	task automatic send_run(input longint value, input int unsigned count);
		repeat (count) begin
			send_sample(value[SAMPLE_W-1:0]);
		end
	endtask

	task automatic test_extremes;
		logic [SAMPLE_W-1:0] patterns [12];
		patterns = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF,
			24'h555555, 24'hAAAAAA, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
			24'h800000, 24'h000000};
		tx_gaps   = 1'b0;
		rx_stalls = 1'b0;
		foreach (patterns[i]) begin
			send_sample(patterns[i]);
		end
		for (int i = 0; i < 8; i++) begin
			send_sample(i[0] ? SAT_NEG : SAT_POS);
		end
	endtask

	// A long negative run followed by full-scale positive drives the output into
	// positive saturation, and the swing back drives it into negative saturation.
	task automatic test_output_saturation;
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
		send_run(SMIN, 300);
		tx_gaps   = 1'b0;
		send_run(SMAX, 350);
		tx_gaps   = 1'b1;
		rx_stalls = 1'b0;
		send_run(SMIN, 250);
	endtask

	task automatic test_random_segments;
		int unsigned kind;
		int unsigned len;
		longint      base;
		longint      v;
		while (samples_sent < TOTAL_SAMPLES) begin
			kind      = $urandom_range(0, 4);
			len       = $urandom_range(20, 150);
			tx_gaps   = $urandom_range(0, 2) != 0;
			rx_stalls = $urandom_range(0, 2) != 0;
			base      = longint'($signed(24'($urandom)));
			for (int i = 0; i < len; i++) begin
				case (kind)
					0: v = longint'($signed(24'($urandom)));
					1: v = clamp24(base + longint'($urandom_range(0, 4000)) - 2000);
					2: v = base[0] ? SMAX : SMIN;
					3: v = longint'($urandom_range(0, 64)) - 32;
					default: v = (i / 16) % 2 ? base : -base;
				endcase
				v = clamp24(v);
				send_sample(v[SAMPLE_W-1:0]);
			end
		end
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready   <= 1'b1;
			stall_left <= draw_gap(rx_stalls);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_samples.size() == 0) begin
				if (mismatches < 10) begin
					$display("unexpected output transaction: %h", m_tdata);
				end
				mismatches++;
			end else begin
				if (m_tdata !== expected_samples[0]) begin
					if (mismatches < 10) begin
						$display("sample_out mismatch: expected %h, got %h",
							expected_samples[0], m_tdata);
					end
					mismatches++;
				end
				void'(expected_samples.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		stall_left   = 0;
		tx_gaps      = 1'b0;
		rx_stalls    = 1'b0;
		samples_sent = 0;
		mismatches   = 0;
		cycle_count  = 0;
		ring_pos     = 0;
		foreach (long_line[i]) begin
			long_line[i] = '0;
		end
		foreach (stage_line[j, i]) begin
			stage_line[j][i] = '0;
		end
		foreach (stage_sum[j]) begin
			stage_sum[j] = 0;
		end
		clk = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_output_saturation();
		test_random_segments();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_samples.size() != 0) begin
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
